>>> rtl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

  localparam int PERM_SIZE     = 256;
  localparam int IDX_W         = $clog2(PERM_SIZE);
  localparam int KEY_WORDS     = 4;
  localparam int KEY_WORD_W    = 64;
  localparam int KW_SEL_W      = $clog2(KEY_WORDS);
  localparam int MAX_KEY_BYTES = 32;
  localparam int LEN_W         = 6;
  localparam int CNT_W         = 12;
  localparam int MAX_SKIP      = 4095;
  localparam int CFG_IDX_W     = 3;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_REKEY   = 2'd0;
  localparam logic [1:0] REQ_DISCARD = 2'd1;
  localparam logic [1:0] REQ_CRYPT   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

  typedef logic [IDX_W-1:0] byte_t;

  // One cycle of traffic to the permutation memory.
  typedef struct packed {
    logic  clr;
    byte_t raddr;
    logic  we;
    byte_t waddr;
    byte_t wdata;
  } perm_req_t;

endpackage

`default_nettype wire

>>> rtl/rc4_ifs.sv
`default_nettype none

interface rc4_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  data_byte;
  logic [11:0] skip_count;

  modport source (output valid, output req_type, output data_byte, output skip_count,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input skip_count,
                output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/rc4_perm_mem.sv
`default_nettype none

module rc4_perm_mem (
  input  wire                     clk,
  input  wire                     rst,
  input  wire rc4_pkg::perm_req_t preq,
  output rc4_pkg::byte_t          rdata
);
  import rc4_pkg::*;

  byte_t                mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] valid;
  byte_t                rd;
  byte_t                raddr_q;
  logic                 vld_q;

  always_ff @(posedge clk) begin
    if (preq.we) begin
      mem[preq.waddr] <= preq.wdata;
    end
    rd      <= mem[preq.raddr];
    raddr_q <= preq.raddr;
  end

  // An entry that was never written since the last clear holds its own index.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid[preq.raddr];
      if (preq.clr) begin
        valid <= '0;
      end else if (preq.we) begin
        valid[preq.waddr] <= 1'b1;
      end
    end
  end

  assign rdata = vld_q ? rd : raddr_q;

endmodule

`default_nettype wire

>>> rtl/rc4_key_regs.sv
`default_nettype none

module rc4_key_regs (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [rc4_pkg::KEY_WORD_W-1:0]    cfg_wdata,
  input  wire [rc4_pkg::LEN_W-1:0]         kidx,
  output rc4_pkg::byte_t                   kbyte,
  output logic [rc4_pkg::LEN_W-1:0]        len_eff
);
  import rc4_pkg::*;

  logic [KEY_WORD_W-1:0] key_word [KEY_WORDS];
  logic [LEN_W-1:0]      key_length;
  logic [KW_SEL_W-1:0]   wsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_word[w] <= '0;
      end
      key_length <= LEN_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_WORD_0: key_word[0] <= cfg_wdata;
        CFG_KEY_WORD_1: key_word[1] <= cfg_wdata;
        CFG_KEY_WORD_2: key_word[2] <= cfg_wdata;
        CFG_KEY_WORD_3: key_word[3] <= cfg_wdata;
        CFG_KEY_LENGTH: key_length <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero length acts as one byte; longer than the key store saturates.
  always_comb begin
    if (key_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_length > LEN_W'(MAX_KEY_BYTES)) begin
      len_eff = LEN_W'(MAX_KEY_BYTES);
    end else begin
      len_eff = key_length;
    end
  end

  assign wsel  = kidx[KW_SEL_W+2:3];
  assign kbyte = kidx[LEN_W-1] ? '0 : key_word[wsel][{kidx[2:0], 3'b000} +: 8];

endmodule

`default_nettype wire

>>> rtl/rc4_stream_cipher.sv
`default_nettype none

// RC4 stream cipher with a single 256-byte permutation memory.
// Input words arrive on req (valid/ready). req_type selects the job: rekey runs
// the key schedule from the key registers and clears both indices, discard
// drops skip_count keystream bytes, crypt XORs data_byte with the next
// keystream byte. Only crypt words produce an output word on res. A word with
// req_type three is taken and ignored.
// The key registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle, as the block itself does not
// enforce it. Each write lands at the clock edge where cfg_we is high. req is
// ready only in the idle state, so one word is worked on at a time.
// Each keystream byte takes the steps read S[i], read S[j] and two write-backs,
// and a crypt word adds the read of S[S[i]+S[j]], since the memory has one read
// and one write port with registered read data.
// After reset the permutation is the identity, both indices are zero and the
// key registers hold zero with a key length of 16. If res stalls, the result
// waits in the output register and the next input word is still accepted;
// only a following crypt result waits until the register is free.
module rc4_stream_cipher (
  input  wire                           clk,
  input  wire                           rst,
  rc4_req_if.sink                       req,
  rc4_out_if.source                     res,
  input  wire                           cfg_we,
  input  wire [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [rc4_pkg::KEY_WORD_W-1:0] cfg_wdata
);
  import rc4_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KRN  = 4'd1;
  localparam logic [3:0] S_KRJ  = 4'd2;
  localparam logic [3:0] S_KW1  = 4'd3;
  localparam logic [3:0] S_KW2  = 4'd4;
  localparam logic [3:0] S_GRI  = 4'd5;
  localparam logic [3:0] S_GRJ  = 4'd6;
  localparam logic [3:0] S_GW1  = 4'd7;
  localparam logic [3:0] S_GW2  = 4'd8;
  localparam logic [3:0] S_GOUT = 4'd9;

  logic [3:0]       state, state_next;
  byte_t            idx_i, idx_i_next;
  byte_t            idx_j, idx_j_next;
  byte_t            n, n_next;
  logic [LEN_W-1:0] kidx, kidx_next, kidx_inc;
  byte_t            si, si_next;
  byte_t            sj, sj_next;
  byte_t            data, data_next;
  logic [CNT_W-1:0] cnt, cnt_next, skip_sat;
  logic             crypt, crypt_next;
  logic             fwd, fwd_next;
  logic             out_valid;
  byte_t            out_byte;
  logic             out_load;
  byte_t            ks;
  byte_t            t_sum;

  perm_req_t        preq;
  byte_t            rdata;
  byte_t            kbyte;
  logic [LEN_W-1:0] len_eff;
  logic             req_fire;

  rc4_perm_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .preq  (preq),
    .rdata (rdata)
  );

  rc4_key_regs u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .kidx      (kidx),
    .kbyte     (kbyte),
    .len_eff   (len_eff)
  );

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign res.valid    = out_valid;
  assign res.out_byte = out_byte;

  assign skip_sat = (req.skip_count > CNT_W'(MAX_SKIP)) ? CNT_W'(MAX_SKIP) : req.skip_count;
  assign t_sum    = si + sj;
  assign kidx_inc = kidx + LEN_W'(1);
  // The keystream read shares its cycle with the write of S[j]; forward it.
  assign ks       = fwd ? si : rdata;

  always_comb begin
    state_next = state;
    idx_i_next = idx_i;
    idx_j_next = idx_j;
    n_next     = n;
    kidx_next  = kidx;
    si_next    = si;
    sj_next    = sj;
    data_next  = data;
    cnt_next   = cnt;
    crypt_next = crypt;
    fwd_next   = fwd;
    out_load   = 1'b0;
    preq       = '0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_REKEY: begin
              preq.clr   = 1'b1;
              n_next     = '0;
              kidx_next  = '0;
              idx_j_next = '0;
              state_next = S_KRN;
            end
            REQ_DISCARD: begin
              crypt_next = 1'b0;
              cnt_next   = skip_sat;
              if (skip_sat != '0) begin
                state_next = S_GRI;
              end
            end
            REQ_CRYPT: begin
              crypt_next = 1'b1;
              data_next  = req.data_byte;
              state_next = S_GRI;
            end
            default: ;
          endcase
        end
      end
      S_KRN: begin
        preq.raddr = n;
        state_next = S_KRJ;
      end
      S_KRJ: begin
        si_next    = rdata;
        idx_j_next = idx_j + rdata + kbyte;
        preq.raddr = idx_j_next;
        state_next = S_KW1;
      end
      S_KW1: begin
        preq.we    = 1'b1;
        preq.waddr = n;
        preq.wdata = rdata;
        state_next = S_KW2;
      end
      S_KW2: begin
        preq.we    = 1'b1;
        preq.waddr = idx_j;
        preq.wdata = si;
        n_next     = n + 1'b1;
        kidx_next  = (kidx_inc == len_eff) ? '0 : kidx_inc;
        if (n == IDX_W'(PERM_SIZE - 1)) begin
          idx_i_next = '0;
          idx_j_next = '0;
          state_next = S_IDLE;
        end else begin
          state_next = S_KRN;
        end
      end
      S_GRI: begin
        idx_i_next = idx_i + 1'b1;
        preq.raddr = idx_i_next;
        state_next = S_GRJ;
      end
      S_GRJ: begin
        si_next    = rdata;
        idx_j_next = idx_j + rdata;
        preq.raddr = idx_j_next;
        state_next = S_GW1;
      end
      S_GW1: begin
        preq.we    = 1'b1;
        preq.waddr = idx_i;
        preq.wdata = rdata;
        sj_next    = rdata;
        state_next = S_GW2;
      end
      S_GW2: begin
        preq.we    = 1'b1;
        preq.waddr = idx_j;
        preq.wdata = si;
        preq.raddr = t_sum;
        fwd_next   = (t_sum == idx_j);
        if (crypt) begin
          state_next = S_GOUT;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = (cnt == CNT_W'(1)) ? S_IDLE : S_GRI;
        end
      end
      S_GOUT: begin
        // Keep addressing the keystream entry so the read data holds through a stall.
        preq.raddr = t_sum;
        if (!out_valid || res.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx_i <= idx_i_next;
      idx_j <= idx_j_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n     <= n_next;
    kidx  <= kidx_next;
    si    <= si_next;
    sj    <= sj_next;
    data  <= data_next;
    cnt   <= cnt_next;
    crypt <= crypt_next;
    fwd   <= fwd_next;
    if (out_load) begin
      out_byte <= data ^ ks;
    end
  end

  // The last schedule step leaves both indices at zero and returns to idle.
  a_rekey_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_KW2 && n == IDX_W'(PERM_SIZE - 1)) |=>
      (state == S_IDLE && idx_i == '0 && idx_j == '0))
    else $error("rekey did not finish cleanly");

  // A finished crypt result waits while the output register is still occupied.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_GOUT && out_valid && !res.ready) |=> (state == S_GOUT && out_valid))
    else $error("crypt result would overwrite a pending output");

  // A memory write never coincides with the permutation reset.
  a_clr_we: assert property (@(posedge clk) disable iff (rst)
    !(preq.clr && preq.we))
    else $error("permutation clear collides with a write");

  // Input is taken only with the sequencer at rest.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != S_KW1 && state != S_KW2 && state != S_GW1 && state != S_GW2))
    else $error("input accepted outside idle");

endmodule

`default_nettype wire
